[rtl/core/mkt_pkg.sv]
// shared types and constants of the keypad key tracker
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps
`default_nettype none
package mkt_pkg;

  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int DIM_W    = 3;
  localparam int MATRIX_W = 16;
  localparam int KEY_W    = 4;
  localparam int SLOT_W   = 4;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE   = 3'd4;

  // register reset values
  localparam logic [MS_W-1:0]  DEBOUNCE_RST = 16'd10;
  localparam logic [MS_W-1:0]  HOLD_RST     = 16'd300;
  localparam logic [DIM_W-1:0] ROWS_RST     = 3'd4;
  localparam logic [DIM_W-1:0] COLS_RST     = 3'd4;

  typedef enum logic [1:0] {
    KS_IDLE     = 2'd0,
    KS_PRESSED  = 2'd1,
    KS_HOLD     = 2'd2,
    KS_RELEASED = 2'd3
  } key_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CHECK,
    SQ_FREE,
    SQ_SEARCH,
    SQ_APPLY,
    SQ_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_code;
    key_state_t        new_state;
    logic [SLOT_W-1:0] slot_index;
  } key_event_t;

  typedef struct packed {
    logic push;
    logic start;
  } evbuf_ctl_t;

endpackage
`default_nettype wire

[rtl/core/mkt_in_if.sv]
// input channel: one item per millisecond tick with the sampled key matrix
// depends on mkt_pkg
`timescale 1ns / 1ps
`default_nettype none
interface mkt_in_if;
  logic                          valid;
  logic                          ready;
  logic [mkt_pkg::MATRIX_W-1:0]  pressed_matrix;

  modport source (output valid, output pressed_matrix, input ready);
  modport sink   (input valid, input pressed_matrix, output ready);
endinterface
`default_nettype wire

[rtl/core/mkt_out_if.sv]
// result channel: one item per reported key state transition
// depends on mkt_pkg
`timescale 1ns / 1ps
`default_nettype none
interface mkt_out_if;
  logic                         valid;
  logic                         ready;
  logic [mkt_pkg::KEY_W-1:0]    key_code;
  logic [1:0]                   new_state;
  logic [mkt_pkg::SLOT_W-1:0]   slot_index;
  logic                         last_event;

  modport source (output valid, output key_code, output new_state, output slot_index,
                  output last_event, input ready);
  modport sink   (input valid, input key_code, input new_state, input slot_index,
                  input last_event, output ready);
endinterface
`default_nettype wire

[rtl/core/mkt_cmp.sv]
// shared time unit: elapsed = a - b (mod 2^32), flags elapsed > limit
// depends on mkt_pkg; serves both the debounce and the hold check
`timescale 1ns / 1ps
`default_nettype none
module mkt_cmp (
  input  wire logic [mkt_pkg::TIME_W-1:0] a,
  input  wire logic [mkt_pkg::TIME_W-1:0] b,
  input  wire logic [mkt_pkg::MS_W-1:0]   limit,
  output logic                            gt
);
  logic [mkt_pkg::TIME_W-1:0] elapsed;

  always_comb begin
    elapsed = a - b;
    gt      = elapsed > {{(mkt_pkg::TIME_W - mkt_pkg::MS_W){1'b0}}, limit};
  end
endmodule
`default_nettype wire

[rtl/core/mkt_evbuf.sv]
// event buffer: collects the items of one scan, then drains them through
// an output register, flagging the final one; depends on mkt_pkg, mkt_out_if
`timescale 1ns / 1ps
`default_nettype none
module mkt_evbuf #(
  parameter int LIST_SLOTS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mkt_pkg::evbuf_ctl_t ctl,
  input  wire mkt_pkg::key_event_t entry,
  output logic                     busy,
  mkt_out_if.source                out_ch
);
  localparam int CW = $clog2(LIST_SLOTS + 1);
  localparam int EW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;

  mkt_pkg::key_event_t ev_mem [LIST_SLOTS];
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       rd_r;
  logic                draining_r;
  logic                out_vld_r;
  mkt_pkg::key_event_t out_ev_r;
  logic                out_last_r;
  logic                slot_free;
  logic                have_more;
  logic                load;
  logic                finish;

  always_comb begin
    slot_free = out_vld_r == 1'b0 || out_ch.ready == 1'b1;
    have_more = rd_r != cnt_r;
    load      = draining_r && have_more && slot_free;
    finish    = draining_r && !have_more && slot_free;
    busy      = draining_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rd_r       <= '0;
      draining_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      // items beyond the list size are dropped
      if (ctl.push && cnt_r != CW'(LIST_SLOTS)) begin
        ev_mem[cnt_r[EW-1:0]] <= entry;
        cnt_r <= cnt_r + CW'(1);
      end
      if (ctl.start) begin
        draining_r <= 1'b1;
      end
      if (load) begin
        out_vld_r  <= 1'b1;
        out_ev_r   <= ev_mem[rd_r[EW-1:0]];
        out_last_r <= (rd_r + CW'(1)) == cnt_r;
        rd_r       <= rd_r + CW'(1);
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (finish) begin
        draining_r <= 1'b0;
        cnt_r      <= '0;
        rd_r       <= '0;
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.key_code   = out_ev_r.key_code;
  assign out_ch.new_state  = out_ev_r.new_state;
  assign out_ch.slot_index = out_ev_r.slot_index;
  assign out_ch.last_event = out_last_r;
endmodule
`default_nettype wire

[rtl/core/matrix_keypad_key_tracker.sv]
// Keypad key tracker. One item per tick; the block is not ready while it works on one.
// Ticks without a scan pass only accept and check. A scan: accept, check and freeing of each
// slot, then per scanned key code a search (one slot compared per cycle in the shared search)
// and an apply step for each code that has a slot (at most LIST_SLOTS codes do), then
// the drain of the results, which can stall on the result channel.
// Synchronous active-low reset: registers to defaults, slot list free, timers zero.
// Depends on mkt_pkg, mkt_in_if, mkt_out_if, mkt_cmp, mkt_evbuf.
`timescale 1ns / 1ps
`default_nettype none
module matrix_keypad_key_tracker #(
  parameter int LIST_SLOTS = 10,
  parameter int MAX_ROWS   = 4,
  parameter int MAX_COLS   = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mkt_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [mkt_pkg::MS_W-1:0]         cfg_data,
  mkt_in_if.sink                                in_ch,
  mkt_out_if.source                             out_ch
);
  localparam int SW = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam int BW = 7;

  // configuration
  logic [mkt_pkg::MS_W-1:0]  debounce_r;
  logic [mkt_pkg::MS_W-1:0]  hold_r;
  logic [mkt_pkg::DIM_W-1:0] rows_r;
  logic [mkt_pkg::DIM_W-1:0] cols_r;
  logic                      single_r;

  // timers and the latched matrix
  logic [mkt_pkg::TIME_W-1:0]   time_now_r;
  logic [mkt_pkg::TIME_W-1:0]   last_scan_r;
  logic [mkt_pkg::TIME_W-1:0]   hold_start_r;
  logic [mkt_pkg::MATRIX_W-1:0] matrix_r;

  // slot list
  logic                       used_r  [LIST_SLOTS];
  logic [mkt_pkg::KEY_W-1:0]  scode_r [LIST_SLOTS];
  mkt_pkg::key_state_t        sstate_r[LIST_SLOTS];

  // sequencer
  mkt_pkg::seq_state_t        state_r, state_nxt;
  logic [SW-1:0]              idx_r;
  logic                       hit_r;
  logic [SW-1:0]              hit_idx_r;
  logic                       free_r;
  logic [SW-1:0]              free_idx_r;
  logic [mkt_pkg::DIM_W-1:0]  row_r;
  logic [mkt_pkg::DIM_W-1:0]  col_r;
  logic [mkt_pkg::KEY_W-1:0]  code_r;

  logic [mkt_pkg::DIM_W-1:0]  rows_eff;
  logic [mkt_pkg::DIM_W-1:0]  cols_eff;
  logic [BW-1:0]              bit_idx;
  logic                       closed;
  logic                       idx_last;
  logic                       col_last;
  logic                       code_last;
  logic                       cur_hit;
  logic                       cur_free;
  logic                       hit_any;
  logic                       free_any;
  logic [SW-1:0]              hit_sel;
  logic [SW-1:0]              free_sel;
  mkt_pkg::key_state_t        cur_st;
  mkt_pkg::key_state_t        new_st;
  logic                       move;
  logic                       hold_load;

  logic [mkt_pkg::TIME_W-1:0] cmp_b;
  logic [mkt_pkg::MS_W-1:0]   cmp_limit;
  logic                       cmp_gt;
  logic                       in_accept;
  mkt_pkg::evbuf_ctl_t        ev_ctl;
  mkt_pkg::key_event_t        ev_entry;
  logic                       ev_busy;

  mkt_cmp u_cmp (
    .a     (time_now_r),
    .b     (cmp_b),
    .limit (cmp_limit),
    .gt    (cmp_gt)
  );

  mkt_evbuf #(.LIST_SLOTS(LIST_SLOTS)) u_evbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ev_ctl),
    .entry  (ev_entry),
    .busy   (ev_busy),
    .out_ch (out_ch)
  );

  // scan geometry and the per-slot search
  always_comb begin
    rows_eff  = (rows_r > MAX_ROWS) ? mkt_pkg::DIM_W'(MAX_ROWS) : rows_r;
    cols_eff  = (cols_r > MAX_COLS) ? mkt_pkg::DIM_W'(MAX_COLS) : cols_r;
    bit_idx   = BW'(row_r) * BW'(MAX_COLS) + BW'(col_r);
    closed    = (bit_idx < BW'(mkt_pkg::MATRIX_W)) && matrix_r[bit_idx[3:0]];
    col_last  = (col_r + 3'd1) == cols_eff;
    code_last = col_last && ((row_r + 3'd1) == rows_eff);
    idx_last  = idx_r == SW'(LIST_SLOTS - 1);
    cur_hit   = used_r[idx_r] && scode_r[idx_r] == code_r;
    cur_free  = !used_r[idx_r];
    hit_any   = hit_r || cur_hit;
    free_any  = free_r || cur_free;
    hit_sel   = hit_r ? hit_idx_r : idx_r;
    free_sel  = free_r ? free_idx_r : idx_r;
  end

  // key state step of the selected slot; hold is tested before release
  always_comb begin
    cur_st    = sstate_r[idx_r];
    new_st    = cur_st;
    move      = 1'b0;
    hold_load = 1'b0;
    case (cur_st)
      mkt_pkg::KS_IDLE: begin
        if (closed) begin
          new_st    = mkt_pkg::KS_PRESSED;
          move      = 1'b1;
          hold_load = 1'b1;
        end
      end
      mkt_pkg::KS_PRESSED: begin
        if (cmp_gt) begin
          new_st = mkt_pkg::KS_HOLD;
          move   = 1'b1;
        end else if (!closed) begin
          new_st = mkt_pkg::KS_RELEASED;
          move   = 1'b1;
        end
      end
      mkt_pkg::KS_HOLD: begin
        if (!closed) begin
          new_st = mkt_pkg::KS_RELEASED;
          move   = 1'b1;
        end
      end
      default: begin
        new_st = mkt_pkg::KS_IDLE;
        move   = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mkt_pkg::SQ_IDLE: begin
        if (in_ch.valid) state_nxt = mkt_pkg::SQ_CHECK;
      end
      mkt_pkg::SQ_CHECK: begin
        state_nxt = cmp_gt ? mkt_pkg::SQ_FREE : mkt_pkg::SQ_IDLE;
      end
      mkt_pkg::SQ_FREE: begin
        if (idx_last) begin
          if (rows_eff == '0 || cols_eff == '0) state_nxt = mkt_pkg::SQ_DRAIN;
          else                                  state_nxt = mkt_pkg::SQ_SEARCH;
        end
      end
      mkt_pkg::SQ_SEARCH: begin
        if (idx_last) begin
          if (hit_any || (closed && free_any)) state_nxt = mkt_pkg::SQ_APPLY;
          else if (code_last)                  state_nxt = mkt_pkg::SQ_DRAIN;
        end
      end
      mkt_pkg::SQ_APPLY: begin
        state_nxt = code_last ? mkt_pkg::SQ_DRAIN : mkt_pkg::SQ_SEARCH;
      end
      mkt_pkg::SQ_DRAIN: begin
        if (!ev_busy) state_nxt = mkt_pkg::SQ_IDLE;
      end
      default: state_nxt = mkt_pkg::SQ_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready  = state_r == mkt_pkg::SQ_IDLE;
    in_accept    = in_ch.valid && in_ch.ready;
    cmp_b        = (state_r == mkt_pkg::SQ_CHECK) ? last_scan_r : hold_start_r;
    cmp_limit    = (state_r == mkt_pkg::SQ_CHECK) ? debounce_r : hold_r;
    ev_ctl.push  = state_r == mkt_pkg::SQ_APPLY && move &&
                   (!single_r || idx_r == '0);
    ev_ctl.start = state_nxt == mkt_pkg::SQ_DRAIN && state_r != mkt_pkg::SQ_DRAIN;
    ev_entry.key_code   = code_r;
    ev_entry.new_state  = new_st;
    ev_entry.slot_index = mkt_pkg::SLOT_W'(idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= mkt_pkg::DEBOUNCE_RST;
      hold_r       <= mkt_pkg::HOLD_RST;
      rows_r       <= mkt_pkg::ROWS_RST;
      cols_r       <= mkt_pkg::COLS_RST;
      single_r     <= 1'b0;
      time_now_r   <= '0;
      last_scan_r  <= '0;
      hold_start_r <= '0;
      state_r      <= mkt_pkg::SQ_IDLE;
      idx_r        <= '0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      for (int i = 0; i < LIST_SLOTS; i++) begin
        used_r[i]   <= 1'b0;
        scode_r[i]  <= '0;
        sstate_r[i] <= mkt_pkg::KS_IDLE;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          mkt_pkg::CFG_DEBOUNCE: debounce_r <= cfg_data;
          mkt_pkg::CFG_HOLD:     hold_r     <= cfg_data;
          mkt_pkg::CFG_ROWS:     rows_r     <= cfg_data[mkt_pkg::DIM_W-1:0];
          mkt_pkg::CFG_COLS:     cols_r     <= cfg_data[mkt_pkg::DIM_W-1:0];
          mkt_pkg::CFG_SINGLE:   single_r   <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        mkt_pkg::SQ_IDLE: begin
          if (in_accept) begin
            time_now_r <= time_now_r + 32'd1;
            matrix_r   <= in_ch.pressed_matrix;
          end
        end
        mkt_pkg::SQ_CHECK: begin
          if (cmp_gt) last_scan_r <= time_now_r;
          idx_r <= '0;
        end
        mkt_pkg::SQ_FREE: begin
          // idle slots give up their key
          if (!used_r[idx_r] || sstate_r[idx_r] == mkt_pkg::KS_IDLE) begin
            used_r[idx_r]   <= 1'b0;
            scode_r[idx_r]  <= '0;
            sstate_r[idx_r] <= mkt_pkg::KS_IDLE;
          end
          idx_r  <= idx_last ? '0 : idx_r + SW'(1);
          row_r  <= '0;
          col_r  <= '0;
          code_r <= '0;
          hit_r  <= 1'b0;
          free_r <= 1'b0;
        end
        mkt_pkg::SQ_SEARCH: begin
          if (!idx_last) begin
            hit_r      <= hit_any;
            hit_idx_r  <= hit_sel;
            free_r     <= free_any;
            free_idx_r <= free_sel;
            idx_r      <= idx_r + SW'(1);
          end else if (hit_any) begin
            idx_r <= hit_sel;
          end else if (closed && free_any) begin
            // new key claims the first free slot
            idx_r              <= free_sel;
            used_r[free_sel]   <= 1'b1;
            scode_r[free_sel]  <= code_r;
            sstate_r[free_sel] <= mkt_pkg::KS_IDLE;
          end else begin
            idx_r  <= '0;
            hit_r  <= 1'b0;
            free_r <= 1'b0;
            code_r <= code_r + 4'd1;
            if (col_last) begin
              col_r <= '0;
              row_r <= row_r + 3'd1;
            end else begin
              col_r <= col_r + 3'd1;
            end
          end
        end
        mkt_pkg::SQ_APPLY: begin
          if (move) sstate_r[idx_r] <= new_st;
          if (hold_load) hold_start_r <= time_now_r;
          idx_r  <= '0;
          hit_r  <= 1'b0;
          free_r <= 1'b0;
          code_r <= code_r + 4'd1;
          if (col_last) begin
            col_r <= '0;
            row_r <= row_r + 3'd1;
          end else begin
            col_r <= col_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[dv/matrix_keypad_key_tracker_test.sv]
// self-checking testbench for matrix_keypad_key_tracker: directed ticks, then random key traffic
// ticks are scored by a slot-list tracker or the plan; depends on mkt_pkg, mkt_in_if, mkt_out_if
`timescale 1ns / 1ps
module matrix_keypad_key_tracker_test;

  localparam int KEY_W     = mkt_pkg::KEY_W;
  localparam int SLOT_W    = mkt_pkg::SLOT_W;
  localparam int CFG_IDX_W = mkt_pkg::CFG_IDX_W;
  localparam int MS_W      = mkt_pkg::MS_W;
  localparam int TIME_W    = mkt_pkg::TIME_W;
  localparam int DIM_W     = mkt_pkg::DIM_W;
  localparam int MATRIX_W  = mkt_pkg::MATRIX_W;

  localparam int SLOTS             = 10;
  localparam int ROW_MAX           = 4;
  localparam int COL_MAX           = 4;
  localparam int SETTLE_CYCLES     = 256;
  localparam int HOLD_OFF_CYCLES   = 400;
  localparam int WATCHDOG_LIMIT    = 20000;
  localparam int RANDOM_TICKS      = 500;
  localparam int MIN_RANDOM_EVENTS = 48;
  localparam int MAX_PHASES        = 80;
  localparam int SHOWN_MISMATCHES  = 10;

  typedef struct packed {
    logic [KEY_W-1:0]    key_code;
    mkt_pkg::key_state_t new_state;
    logic [SLOT_W-1:0]   slot_index;
    logic                last_event;
  } key_report_t;

  // one line of the directed plan; value is the matrix for a tick or the register data
  typedef struct packed {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [MS_W-1:0]      value;
    bit                   typed;
    bit                   typed_one;
    key_report_t          want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [MS_W-1:0]      cfg_data;

  mkt_in_if  in_ch ();
  mkt_out_if out_ch ();

  matrix_keypad_key_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker copy of the slot list, timers and registers
  logic                slot_busy [SLOTS];
  logic [KEY_W-1:0]    slot_key [SLOTS];
  mkt_pkg::key_state_t slot_st [SLOTS];
  logic [TIME_W-1:0]   tick_count;
  logic [TIME_W-1:0]   last_scan;
  logic [TIME_W-1:0]   hold_since;
  logic [MS_W-1:0]     debounce;
  logic [MS_W-1:0]     hold_limit;
  logic [DIM_W-1:0]    rows;
  logic [DIM_W-1:0]    cols;
  logic                single_only;

  key_report_t tick_events [$];
  key_report_t reports_due [$];
  plan_row_t   plan [$];
  key_report_t want_ev;

  int  mismatches = 0;
  int  ticks_sent = 0;
  int  random_ticks = 0;
  int  random_scans = 0;
  int  events_due = 0;
  int  events_taken = 0;
  int  reg_writes = 0;
  int  hold_offs = 0;
  int  pauses = 0;
  int  idle_cycles = 0;
  bit  settled;
  bit  hold_off_req;
  bit  send_idle;
  bit  take_idle;

  task automatic enter_state(input int s, input mkt_pkg::key_state_t st);
    key_report_t ev;
    slot_st[s] = st;
    if ((!single_only || s == 0) && tick_events.size() < SLOTS) begin
      ev.key_code   = slot_key[s];
      ev.new_state  = st;
      ev.slot_index = SLOT_W'(s);
      ev.last_event = 1'b0;
      tick_events.push_back(ev);
    end
  endtask

  task automatic step_slot(input int s, input bit closed);
    logic [TIME_W-1:0] held_for;
    held_for = tick_count - hold_since;
    case (slot_st[s])
      mkt_pkg::KS_IDLE: begin
        if (closed) begin
          enter_state(s, mkt_pkg::KS_PRESSED);
          hold_since = tick_count;
        end
      end
      // shared hold timer wins over release
      mkt_pkg::KS_PRESSED: begin
        if (held_for > TIME_W'(hold_limit)) enter_state(s, mkt_pkg::KS_HOLD);
        else if (!closed) enter_state(s, mkt_pkg::KS_RELEASED);
      end
      mkt_pkg::KS_HOLD: begin
        if (!closed) enter_state(s, mkt_pkg::KS_RELEASED);
      end
      default: enter_state(s, mkt_pkg::KS_IDLE);
    endcase
  endtask

  task automatic track_tick(input logic [MATRIX_W-1:0] m, output bit scanned);
    int nr;
    int nc;
    int found;
    logic [KEY_W-1:0] code;
    tick_events.delete();
    tick_count = tick_count + 1;
    scanned = (tick_count - last_scan) > TIME_W'(debounce);
    if (scanned) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_busy[i] || slot_st[i] == mkt_pkg::KS_IDLE) begin
          slot_busy[i] = 1'b0;
          slot_key[i]  = '0;
          slot_st[i]   = mkt_pkg::KS_IDLE;
        end
      end
      nr = (rows > ROW_MAX) ? ROW_MAX : int'(rows);
      nc = (cols > COL_MAX) ? COL_MAX : int'(cols);
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          code  = KEY_W'(r * nc + c);
          found = -1;
          for (int i = 0; i < SLOTS && found < 0; i++)
            if (slot_busy[i] && slot_key[i] == code) found = i;
          if (found >= 0) begin
            step_slot(found, m[r * COL_MAX + c]);
          end else if (m[r * COL_MAX + c]) begin
            // newly closed key takes the first free slot, dropped if the list is full
            for (int i = 0; i < SLOTS && found < 0; i++) begin
              if (!slot_busy[i]) begin
                found        = i;
                slot_busy[i] = 1'b1;
                slot_key[i]  = code;
                slot_st[i]   = mkt_pkg::KS_IDLE;
                step_slot(i, 1'b1);
              end
            end
          end
        end
      end
      last_scan = tick_count;
    end
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic drive_tick(input logic [MATRIX_W-1:0] m, input bit typed, input bit typed_one,
                            input key_report_t want, output bit scanned);
    int gap;
    key_report_t ev;
    gap = send_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pressed_matrix <= m;
    do @(posedge clk); while (!in_ch.ready);
    track_tick(m, scanned);
    ticks_sent++;
    settled = 1'b0;
    if (typed) begin
      if (typed_one) begin
        reports_due.push_back(want);
        events_due++;
      end
    end else begin
      for (int i = 0; i < tick_events.size(); i++) begin
        ev = tick_events[i];
        ev.last_event = (i == tick_events.size() - 1);
        reports_due.push_back(ev);
        events_due++;
      end
    end
    @(negedge clk);
  endtask

  // wait for every due event, then for a tick that produced nothing to finish
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    settled = 1'b1;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] v);
    if (!settled) quiesce();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mkt_pkg::CFG_DEBOUNCE: debounce    = v;
      mkt_pkg::CFG_HOLD:     hold_limit  = v;
      mkt_pkg::CFG_ROWS:     rows        = v[DIM_W-1:0];
      mkt_pkg::CFG_COLS:     cols        = v[DIM_W-1:0];
      mkt_pkg::CFG_SINGLE:   single_only = v[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] v);
    plan_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.value   = v;
    plan.push_back(row);
  endfunction

  function automatic void add_tick(input logic [MATRIX_W-1:0] m);
    plan_row_t row;
    row       = '0;
    row.value = m;
    plan.push_back(row);
  endfunction

  function automatic void add_silent(input logic [MATRIX_W-1:0] m);
    plan_row_t row;
    row       = '0;
    row.value = m;
    row.typed = 1'b1;
    plan.push_back(row);
  endfunction

  function automatic void add_expect(input logic [MATRIX_W-1:0] m, input logic [KEY_W-1:0] key,
                                     input mkt_pkg::key_state_t st,
                                     input logic [SLOT_W-1:0] slot);
    plan_row_t row;
    row                 = '0;
    row.value           = m;
    row.typed           = 1'b1;
    row.typed_one       = 1'b1;
    row.want.key_code   = key;
    row.want.new_state  = st;
    row.want.slot_index = slot;
    row.want.last_event = 1'b1;
    plan.push_back(row);
  endfunction

  // result side: own stall per item, plus the long hold-off on request
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        wait_n = take_idle ? $urandom_range(0, 14) : 0;
        if (wait_n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (wait_n) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && !hold_off_req);
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      events_taken++;
      if (reports_due.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("unexpected event: key %0d state %0d slot %0d last %0d",
                   out_ch.key_code, out_ch.new_state, out_ch.slot_index, out_ch.last_event);
      end else begin
        want_ev = reports_due.pop_front();
        if (out_ch.key_code !== want_ev.key_code || out_ch.new_state !== want_ev.new_state ||
            out_ch.slot_index !== want_ev.slot_index ||
            out_ch.last_event !== want_ev.last_event) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("event mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want_ev.key_code, want_ev.new_state, want_ev.slot_index,
                     want_ev.last_event, out_ch.key_code, out_ch.new_state,
                     out_ch.slot_index, out_ch.last_event);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d events still due", idle_cycles,
               reports_due.size());
      $display("matrix_keypad_key_tracker test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit              scanned;
    bit              pressure;
    int              phase;
    int              n_ticks;
    int              pick;
    int              b;
    int              random_events;
    logic [MS_W-1:0] v;
    logic [MATRIX_W-1:0] held;
    logic [MATRIX_W-1:0] m;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.pressed_matrix = '0;
    hold_off_req         = 1'b0;
    send_idle            = 1'b1;
    take_idle            = 1'b1;
    settled              = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_key[i]  = '0;
      slot_st[i]   = mkt_pkg::KS_IDLE;
    end
    tick_count  = '0;
    last_scan   = '0;
    hold_since  = '0;
    debounce    = mkt_pkg::DEBOUNCE_RST;
    hold_limit  = mkt_pkg::HOLD_RST;
    rows        = mkt_pkg::ROWS_RST;
    cols        = mkt_pkg::COLS_RST;
    single_only = 1'b0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: first tick after reset is inside the debounce window
    add_silent(16'hFFFF);
    add_reg(mkt_pkg::CFG_DEBOUNCE, 16'd0);
    add_expect(16'h0001, 4'd0, mkt_pkg::KS_PRESSED, 4'd0);
    add_tick(16'h8000);
    add_tick(16'h0000);
    add_tick(16'hFFFF);        // more keys than slots
    add_reg(mkt_pkg::CFG_HOLD, 16'd0);
    add_tick(16'hFFFF);
    add_tick(16'hFFFF);
    add_tick(16'h0000);
    add_tick(16'h0000);
    add_reg(mkt_pkg::CFG_ROWS, 16'd2);  // codes remap, stale slots stay put
    add_reg(mkt_pkg::CFG_COLS, 16'd3);
    add_tick(16'h0077);
    add_tick(16'h0000);
    add_reg(mkt_pkg::CFG_ROWS, 16'd0);
    add_silent(16'hFFFF);      // empty scan area
    add_reg(mkt_pkg::CFG_ROWS, 16'd7);  // saturates to the full matrix
    add_reg(mkt_pkg::CFG_COLS, 16'd7);
    add_tick(16'hFFFF);
    add_reg(mkt_pkg::CFG_SINGLE, 16'd1);
    add_tick(16'h0000);
    add_tick(16'hFFFF);
    add_reg(mkt_pkg::CFG_DEBOUNCE, 16'hFFFF);
    add_reg(mkt_pkg::CFG_HOLD, 16'hFFFF);
    add_silent(16'hFFFF);

    foreach (plan[i]) begin
      if (plan[i].is_reg) set_reg(plan[i].reg_idx, plan[i].value);
      else drive_tick(plan[i].value, plan[i].typed, plan[i].typed_one, plan[i].want, scanned);
    end

    // random phases: mostly keys held over several ticks, some noise
    held  = '0;
    phase = 0;
    random_events = events_due;
    while ((random_ticks < RANDOM_TICKS || events_due - random_events < MIN_RANDOM_EVENTS) &&
           phase < MAX_PHASES) begin
      pressure = (phase == 2);
      pick = $urandom_range(0, 19);
      if (pressure || pick < 12) v = 16'd0;
      else if (pick < 17) v = MS_W'($urandom_range(1, 3));
      else if (pick < 19) v = MS_W'($urandom_range(4, 12));
      else v = 16'hFFFF;
      set_reg(mkt_pkg::CFG_DEBOUNCE, v);
      pick = $urandom_range(0, 19);
      if (pick < 12) v = MS_W'($urandom_range(0, 6));
      else if (pick < 18) v = MS_W'($urandom_range(7, 40));
      else if (pick == 18) v = 16'hFFFF;
      else v = MS_W'($urandom);
      set_reg(mkt_pkg::CFG_HOLD, v);
      pick = $urandom_range(0, 11);
      if (pressure) v = 16'd4;
      else if (pick == 0) v = 16'd0;
      else if (pick == 1) v = MS_W'($urandom_range(5, 7));
      else v = MS_W'($urandom_range(1, 4));
      set_reg(mkt_pkg::CFG_ROWS, v);
      pick = $urandom_range(0, 11);
      if (pressure) v = 16'd4;
      else if (pick == 0) v = 16'd0;
      else if (pick == 1) v = MS_W'($urandom_range(5, 7));
      else v = MS_W'($urandom_range(1, 4));
      set_reg(mkt_pkg::CFG_COLS, v);
      v = (!pressure && $urandom_range(0, 3) == 0) ? 16'd1 : 16'd0;
      set_reg(mkt_pkg::CFG_SINGLE, v);

      send_idle = pressure ? 1'b0 : ($urandom_range(0, 2) != 0);
      take_idle = ($urandom_range(0, 2) != 0);
      if (pressure) hold_off_req = 1'b1;

      n_ticks = $urandom_range(20, 40);
      for (int k = 0; k < n_ticks; k++) begin
        if (k == n_ticks / 2 && $urandom_range(0, 3) == 0) begin
          in_ch.valid <= 1'b0;
          do @(negedge clk); while (reports_due.size() != 0);
          pauses++;
        end
        pick = $urandom_range(0, 19);
        if (pick < 15) begin
          repeat ($urandom_range(0, 2)) begin
            b = $urandom_range(0, MATRIX_W - 1);
            held[b] = ~held[b];
          end
          if ($urandom_range(0, 9) == 0) held = '0;
          m = held;
        end else if (pick < 18) begin
          m = MATRIX_W'($urandom);
        end else begin
          m = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end
        drive_tick(m, 1'b0, 1'b0, '0, scanned);
        random_ticks++;
        if (scanned) random_scans++;
      end
      phase++;
    end

    in_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d ticks over %0d random phases, %0d random ticks scanned; %0d of %0d events",
             ticks_sent, phase, random_scans, events_taken, events_due);
    $display("%0d register writes, %0d receiver hold-offs, %0d sender pauses, %0d mismatches",
             reg_writes, hold_offs, pauses, mismatches);
    if (mismatches == 0) begin
      $display("matrix_keypad_key_tracker test passed");
    end else begin
      $display("matrix_keypad_key_tracker test failed");
    end
    $finish;
  end

endmodule
